/* sv/gfmpi_pkg.sv */
// Package for the GF(2^16) multiply / power / inverse core.
// Holds word types, operation codes, field constants and the
// carry-less multiply and reduction helpers. No dependencies.
package gfmpi_pkg;

  localparam int FieldW = 16;
  localparam int FuncW  = 2;

  localparam logic [FuncW-1:0] FUNC_MUL = 2'd0;
  localparam logic [FuncW-1:0] FUNC_POW = 2'd1;
  localparam logic [FuncW-1:0] FUNC_INV = 2'd2;

  localparam logic [FieldW-1:0] GF_ONE       = 16'h0001;
  localparam logic [FieldW-1:0] GF_ZERO      = 16'h0000;
  // a^(2^16 - 2) = a^-1 for nonzero a
  localparam logic [FieldW-1:0] INV_EXPONENT = 16'hFFFE;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [FieldW-1:0] operand_a;
    logic [FieldW-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0] result;
    logic              no_inverse;
  } rsp_t;

  // 16 x 16 carry-less product, 31 bits
  function automatic logic [2*FieldW-2:0] clmul16(input logic [FieldW-1:0] x,
                                                  input logic [FieldW-1:0] y);
    logic [2*FieldW-2:0] acc;
    acc = '0;
    for (int i = 0; i < FieldW; i++) begin
      if (y[i]) begin
        acc = acc ^ ({15'b0, x} << i);
      end
    end
    return acc;
  endfunction

  // Reduce modulo x^16 + x^5 + x^3 + x + 1 in two folds:
  // x^16 == x^5 + x^3 + x + 1, so the high part is multiplied by 0x2B.
  function automatic logic [FieldW-1:0] gf_reduce(input logic [2*FieldW-2:0] p);
    logic [14:0] h;
    logic [19:0] f1;
    logic [3:0]  t;
    logic [8:0]  f2;
    h  = p[30:16];
    f1 = {5'b0, h} ^ {4'b0, h, 1'b0} ^ {2'b0, h, 3'b0} ^ {h, 5'b0};
    t  = f1[19:16];
    f2 = {5'b0, t} ^ {4'b0, t, 1'b0} ^ {2'b0, t, 3'b0} ^ {t, 5'b0};
    return p[15:0] ^ f1[15:0] ^ {7'b0, f2};
  endfunction

endpackage

/* sv/gf2_16_mul_pow_inverse_core.sv */
// Top level of the GF(2^16) multiply / power / inverse core.
// Sequencer around one shared multiplier. Depends on gfmpi_pkg, gfmpi_mul.
//
//  channel | signals                      | word
//  --------+------------------------------+--------------------------------
//  request | req_valid, req_ready, req    | func, operand_a, operand_b
//  result  | rsp_valid, rsp_ready, rsp    | result, no_inverse
//
// Multiply: S_MUL stores the product, then S_FIN loads the result register.
// Power / inverse: right-to-left square-and-multiply in S_STEP, one
// multiplier pass per cycle; a set low exponent bit is multiplied in and
// cleared, else the base is squared and the exponent shifted right, stopping once the remaining exponent is zero.
// req_ready is high only while the sequencer is idle; a result held in the
// output register does not block the next request. Synchronous reset
// clears the sequencer and rsp_valid.
module gf2_16_mul_pow_inverse_core
  import gfmpi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_STEP,
    S_FIN
  } state_t;

  state_t            state;
  logic [FieldW-1:0] acc;
  logic [FieldW-1:0] base;
  logic [FieldW-1:0] expo;
  logic              flag;

  logic [FieldW-1:0] mul_x;
  logic [FieldW-1:0] mul_y;
  logic [FieldW-1:0] mul_p;

  gfmpi_mul u_mul (
    .x (mul_x),
    .y (mul_y),
    .p (mul_p)
  );

  // operand select for the shared multiplier
  always_comb begin
    mul_x = base;
    mul_y = base;
    case (state)
      S_MUL:   mul_y = expo;
      S_STEP:  if (expo[0]) mul_x = acc;
      default: mul_y = base;
    endcase
  end

  assign req_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // in the finish state the output register is reloaded instead
      if (rsp_valid && rsp_ready && state != S_FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            base <= req.operand_a;
            expo <= (req.func == FUNC_INV) ? INV_EXPONENT : req.operand_b;
            flag <= (req.func == FUNC_INV) && (req.operand_a == GF_ZERO);
            acc  <= (req.func inside {FUNC_MUL, FUNC_POW, FUNC_INV}) ? GF_ONE : GF_ZERO;
            case (req.func)
              FUNC_MUL:           state <= S_MUL;
              FUNC_POW, FUNC_INV: state <= S_STEP;
              default:            state <= S_FIN;
            endcase
          end
        end
        S_MUL: begin
          acc   <= mul_p;
          state <= S_FIN;
        end
        S_STEP: begin
          if (expo == GF_ZERO) begin
            state <= S_FIN;
          end else if (expo[0]) begin
            acc     <= mul_p;
            expo[0] <= 1'b0;
          end else begin
            base <= mul_p;
            expo <= {1'b0, expo[FieldW-1:1]};
          end
        end
        S_FIN: begin
          // wait for the output register to free up
          if (!rsp_valid || rsp_ready) begin
            rsp.result     <= acc;
            rsp.no_inverse <= flag;
            rsp_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while sequencer busy");

  a_flag_zero_result: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.no_inverse) |-> (rsp.result == GF_ZERO))
    else $error("no_inverse set with nonzero result");

  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_FIN))
    else $error("result word loaded outside finish state");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready && state == S_FIN) |=> (state == S_FIN))
    else $error("finish state left while result word still pending");

endmodule

/* sv/gfmpi_mul.sv */
// Shared GF(2^16) multiplier: carry-less product plus reduction.
// Combinational unit. Depends on gfmpi_pkg.
module gfmpi_mul
  import gfmpi_pkg::*;
(
  input  logic [FieldW-1:0] x,
  input  logic [FieldW-1:0] y,
  output logic [FieldW-1:0] p
);

  logic [2*FieldW-2:0] prod;

  assign prod = clmul16(x, y);
  assign p    = gf_reduce(prod);

endmodule

/* verif/tb_gf2_16_mul_pow_inverse_core.sv */
// Self-checking testbench for gf2_16_mul_pow_inverse_core: directed and random
// multiply / power / inverse words with random stalls on both channels.
// Depends on gfmpi_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_gf2_16_mul_pow_inverse_core;
  import gfmpi_pkg::*;

  localparam logic [FuncW-1:0]  FUNC_RSVD   = 2'd3;
  localparam logic [FieldW-1:0] POLY_LOW    = 16'h002B;
  localparam int unsigned       RAND_WORDS  = 400;
  localparam int unsigned       TAIL_CYCLES = 40;
  localparam int unsigned       CYCLE_LIMIT = 400_000;
  localparam int unsigned       MAX_REPORTS = 10;

  typedef struct {
    req_t word;
    bit   drain;
  } req_plan_t;

  typedef struct {
    req_t word;
    rsp_t want;
  } gf_check_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  req_plan_t   req_plan_q[$];
  gf_check_t   field_results_q[$];
  logic        req_took = 1'b0;
  logic        calm = 1'b0;
  int unsigned req_gap = 0;
  int unsigned rsp_stall = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_flags = 0;
  int unsigned err_cnt = 0;
  int unsigned func_cnt[4] = '{0, 0, 0, 0};

  gf2_16_mul_pow_inverse_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shift-and-add, reducing each time the multiplicand overflows
  function automatic logic [FieldW-1:0] gf16_times(input logic [FieldW-1:0] x,
                                                   input logic [FieldW-1:0] y);
    logic [FieldW-1:0] acc;
    logic [FieldW-1:0] sh;
    acc = GF_ZERO;
    sh  = x;
    for (int i = 0; i < FieldW; i++) begin
      if (y[i]) begin
        acc = acc ^ sh;
      end
      sh = sh[FieldW-1] ? ((sh << 1) ^ POLY_LOW) : (sh << 1);
    end
    return acc;
  endfunction

  function automatic logic [FieldW-1:0] gf16_raise(input logic [FieldW-1:0] base,
                                                   input logic [FieldW-1:0] expo);
    logic [FieldW-1:0] acc;
    logic [FieldW-1:0] sq;
    acc = GF_ONE;
    sq  = base;
    for (int i = 0; i < FieldW; i++) begin
      if (expo[i]) begin
        acc = gf16_times(acc, sq);
      end
      sq = gf16_times(sq, sq);
    end
    return acc;
  endfunction

  function automatic rsp_t gf_compute(input req_t w);
    rsp_t r;
    r = '0;
    case (w.func)
      FUNC_MUL: r.result = gf16_times(w.operand_a, w.operand_b);
      FUNC_POW: r.result = gf16_raise(w.operand_a, w.operand_b);
      FUNC_INV: begin
        r.result     = gf16_raise(w.operand_a, INV_EXPONENT);
        r.no_inverse = (w.operand_a == GF_ZERO);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  // mostly short gaps, now and then a long one; none in calm stretches
  function automatic int unsigned gap_len(input logic quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FieldW-1:0] field_value();
    case ($urandom_range(0, 9))
      0:       return GF_ZERO;
      1:       return GF_ONE;
      2:       return 16'hFFFF;
      3:       return GF_ONE << $urandom_range(0, FieldW - 1);
      4:       return 16'($urandom_range(2, 20));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic add_word(input logic [FuncW-1:0] f, input logic [FieldW-1:0] a,
                          input logic [FieldW-1:0] b, input bit drain);
    req_plan_t p;
    p.word.func      = f;
    p.word.operand_a = a;
    p.word.operand_b = b;
    p.drain          = drain;
    req_plan_q.push_back(p);
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    calm      <= ((cycle_cnt >> 11) & 3) == 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_cnt,
               field_results_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // request side: hold until accepted, then gap or next word
  always @(negedge clk) begin : drive_req
    logic next_valid;
    next_valid = req_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!req_valid || req_took) begin
      next_valid = 1'b0;
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
      end else if (req_plan_q.size() > 0 &&
                   !(req_plan_q[0].drain && field_results_q.size() > 0)) begin
        req        <= req_plan_q[0].word;
        next_valid = 1'b1;
        req_gap    <= gap_len(calm);
        req_plan_q.pop_front();
      end
    end
    req_valid <= next_valid;
  end

  always @(negedge clk) begin
    if (rsp_stall > 0) begin
      rsp_ready <= 1'b0;
      rsp_stall <= rsp_stall - 1;
    end else begin
      rsp_ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) begin
        rsp_stall <= gap_len(calm);
      end
    end
  end

  // results are checked before the word accepted on the same edge is queued
  always @(posedge clk) begin : watch
    gf_check_t head;
    req_took <= !rst && req_valid && req_ready;
    if (!rst && rsp_valid && rsp_ready) begin
      if (field_results_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("unexpected result word: result %h no_inverse %b", rsp.result,
                   rsp.no_inverse);
        end
      end else begin
        head = field_results_q.pop_front();
        n_checked++;
        if (rsp.result !== head.want.result || rsp.no_inverse !== head.want.no_inverse) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch: func %0d a %h b %h: expected %h/%b, got %h/%b",
                     head.word.func, head.word.operand_a, head.word.operand_b,
                     head.want.result, head.want.no_inverse, rsp.result, rsp.no_inverse);
          end
        end
      end
    end
    if (!rst && req_valid && req_ready) begin
      head.word = req;
      head.want = gf_compute(req);
      field_results_q.push_back(head);
      n_accepted++;
      func_cnt[req.func]++;
      if (head.want.no_inverse) begin
        n_flags++;
      end
    end
  end

  initial begin : stimulus
    int unsigned      n_total;
    int unsigned      r;
    logic [FuncW-1:0] f;

    add_word(FUNC_MUL, 16'h0000, 16'h0000, 1'b0);
    add_word(FUNC_MUL, 16'hFFFF, 16'hFFFF, 1'b0);
    add_word(FUNC_MUL, 16'h0001, 16'hABCD, 1'b0);
    add_word(FUNC_MUL, 16'h8000, 16'h0002, 1'b0);
    add_word(FUNC_MUL, 16'h8000, 16'h8000, 1'b0);
    add_word(FUNC_MUL, 16'hFFFF, 16'h0000, 1'b0);
    // zero exponent gives one even for a zero base
    add_word(FUNC_POW, 16'h0000, 16'h0000, 1'b0);
    add_word(FUNC_POW, 16'h0000, 16'h0001, 1'b0);
    add_word(FUNC_POW, 16'hFFFF, 16'hFFFF, 1'b0);
    add_word(FUNC_POW, 16'h0002, 16'h8000, 1'b0);
    add_word(FUNC_POW, 16'h1234, 16'h0001, 1'b0);
    add_word(FUNC_POW, 16'h8000, 16'h0000, 1'b0);
    // inverse of zero raises the flag; operand_b must not matter
    add_word(FUNC_INV, 16'h0000, 16'h0000, 1'b1);
    add_word(FUNC_INV, 16'h0000, 16'hFFFF, 1'b0);
    add_word(FUNC_INV, 16'h0001, 16'h0000, 1'b0);
    add_word(FUNC_INV, 16'hFFFF, 16'h5555, 1'b0);
    add_word(FUNC_INV, 16'h8000, 16'h0000, 1'b0);
    add_word(FUNC_INV, 16'h0002, 16'hFFFF, 1'b0);
    add_word(FUNC_RSVD, 16'hFFFF, 16'hFFFF, 1'b0);
    add_word(FUNC_RSVD, 16'h0000, 16'h0000, 1'b0);

    for (int k = 0; k < RAND_WORDS; k++) begin
      r = $urandom_range(0, 19);
      f = (r == 0) ? FUNC_RSVD : FuncW'((r - 1) % 3);
      add_word(f, field_value(), field_value(), k == 150 || k == 300);
    end
    n_total = req_plan_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(n_accepted == n_total && field_results_q.size() == 0)) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
    if (field_results_q.size() != 0) begin
      err_cnt++;
    end

    $display("covered %0d words: %0d mul, %0d pow, %0d inv, %0d unused op",
             n_accepted, func_cnt[FUNC_MUL], func_cnt[FUNC_POW], func_cnt[FUNC_INV],
             func_cnt[FUNC_RSVD]);
    $display("checked %0d results, %0d zero-inverse flags, %0d errors",
             n_checked, n_flags, err_cnt);
    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
sv/gfmpi_pkg.sv
sv/gfmpi_mul.sv
sv/gf2_16_mul_pow_inverse_core.sv
verif/tb_gf2_16_mul_pow_inverse_core.sv
